@@ sv/lps_pkg.sv @@
// Shared types and field widths for the linear prime sieve.
package lps_pkg;

    // Field widths of the stream words.
    localparam int UB_W   = 9;   // upper_bound
    localparam int VAL_W  = 8;   // prime_value, also the mark store entry width
    localparam int IDX_W  = 6;   // prime_index
    localparam int DIV_W  = 9;   // divisor key, wide enough for any number examined
    localparam int S_DATA_W = 16;
    localparam int M_DATA_W = 16;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_MARK_RD,
        ST_MARK_CHK,
        ST_LIST_RD,
        ST_PROD,
        ST_MARK_WR,
        ST_EMIT_RD,
        ST_EMIT_LD,
        ST_NONE
    } lps_state_t;

endpackage

@@ sv/linear_prime_sieve.sv @@
// Linear (Euler) prime sieve: one request in, the primes up to its bound out.
//
// Input channel s_*: one word per request, s_tdata[8:0] is the upper bound.
// A bound above MAX_BOUND is taken as MAX_BOUND. A new word is taken only
// when the previous request has been fully handed to the output register.
// Output channel m_*: one word per prime in ascending order, m_tdata[7:0]
// the prime and m_tdata[13:8] its index; m_tuser is the found flag and
// m_tlast marks the final word of the request. A bound below two gives a
// single word with found cleared and m_tlast set.
// Order of work: the mark store is cleared first, entries zero to B for
// bound B. Each number from two up is then read and checked, and walks the
// prime list; a list step is a list read, a product, then a marking write or a stop.
// Its steps are its marking writes plus one step whose product passes B,
// unless the walk stops first at a dividing prime or at the end of the list.
// Each result is then read from the list and loaded into the output register.
// The mark memory with one read and one write port, and the
// read-modify-write sequence, shape this schedule.
// The output word sits in a register; while the receiver stalls the
// sequencer waits in front of it. Reset returns the block to idle with no
// output word pending; the memories need no reset because every request
// that sieves clears the marks and rewrites the prime list from entry zero.
module linear_prime_sieve
    import lps_pkg::*;
#(
    parameter int MAX_BOUND  = 256,
    parameter int MAX_PRIMES = 64
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // [8:0] upper_bound, rest zero
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,   // [7:0] prime_value, [13:8] prime_index
    output logic                m_tuser,   // [0] found
    output logic                m_tlast
);

    localparam int NUM_W  = $clog2(MAX_BOUND + 1);
    localparam int LIDX_W = (MAX_PRIMES > 1) ? $clog2(MAX_PRIMES) : 1;
    localparam int CNT_W  = $clog2(MAX_PRIMES + 1);
    localparam int PROD_W = NUM_W + VAL_W;

    // Memories: marks hold the marking prime (zero when unmarked).
    logic [VAL_W-1:0] mark_mem [MAX_BOUND+1];
    logic [VAL_W-1:0] list_mem [MAX_PRIMES];

    lps_state_t         state_reg, state_next;
    logic [NUM_W-1:0]   bound_reg, bound_next;
    logic [NUM_W-1:0]   i_reg, i_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [LIDX_W-1:0]  j_reg, j_next;
    logic [DIV_W-1:0]   div_reg, div_next;
    logic [VAL_W-1:0]   p_reg, p_next;
    logic [PROD_W-1:0]  prod_reg, prod_next;
    logic [VAL_W-1:0]   mark_q_reg;
    logic [VAL_W-1:0]   list_q_reg;

    logic               out_valid_reg, out_valid_next;
    logic [VAL_W-1:0]   out_val_reg, out_val_next;
    logic [IDX_W-1:0]   out_idx_reg, out_idx_next;
    logic               out_found_reg, out_found_next;
    logic               out_last_reg, out_last_next;

    logic               mark_we;
    logic [NUM_W-1:0]   mark_waddr;
    logic [VAL_W-1:0]   mark_wdata;
    logic               list_we;

    logic [UB_W-1:0]    ub_in;
    logic [NUM_W-1:0]   bound_sat;
    logic               out_free;
    logic               append;
    logic [CNT_W-1:0]   cnt_after;
    logic               j_last;

    // Bound saturation and small helpers.
    assign ub_in     = s_tdata[UB_W-1:0];
    assign bound_sat = (ub_in > UB_W'(MAX_BOUND)) ? NUM_W'(MAX_BOUND) : NUM_W'(ub_in);
    assign out_free  = !out_valid_reg || m_tready;
    assign append    = (mark_q_reg == '0) && (cnt_reg < CNT_W'(MAX_PRIMES));
    assign cnt_after = append ? cnt_reg + CNT_W'(1) : cnt_reg;
    assign j_last    = (CNT_W'(j_reg) + CNT_W'(1)) == cnt_reg;

    // Mark memory: one write port, one registered read port at the current number.
    always_ff @(posedge aclk) begin
        if (mark_we) begin
            mark_mem[mark_waddr] <= mark_wdata;
        end
        mark_q_reg <= mark_mem[i_reg];
    end

    // Prime list memory: appended at the count, read at the walk index.
    always_ff @(posedge aclk) begin
        if (list_we) begin
            list_mem[cnt_reg[LIDX_W-1:0]] <= VAL_W'(i_reg);
        end
        list_q_reg <= list_mem[j_reg];
    end

    // Control and output registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        bound_reg     <= bound_next;
        i_reg         <= i_next;
        j_reg         <= j_next;
        div_reg       <= div_next;
        p_reg         <= p_next;
        prod_reg      <= prod_next;
        out_val_reg   <= out_val_next;
        out_idx_reg   <= out_idx_next;
        out_found_reg <= out_found_next;
        out_last_reg  <= out_last_next;
    end

    // Sequencer: clear, sieve walk, then emit; a bound below two goes straight to the no-prime word.
    always_comb begin
        state_next     = state_reg;
        bound_next     = bound_reg;
        i_next         = i_reg;
        cnt_next       = cnt_reg;
        j_next         = j_reg;
        div_next       = div_reg;
        p_next         = p_reg;
        prod_next      = prod_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_val_next   = out_val_reg;
        out_idx_next   = out_idx_reg;
        out_found_next = out_found_reg;
        out_last_next  = out_last_reg;
        mark_we        = 1'b0;
        mark_waddr     = i_reg;
        mark_wdata     = '0;
        list_we        = 1'b0;
        s_tready       = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    bound_next = bound_sat;
                    i_next     = '0;
                    state_next = (bound_sat < NUM_W'(2)) ? ST_NONE : ST_CLEAR;
                end
            end
            ST_CLEAR: begin
                mark_we = 1'b1;
                if (i_reg == bound_reg) begin
                    i_next     = NUM_W'(2);
                    cnt_next   = '0;
                    state_next = ST_MARK_RD;
                end else begin
                    i_next = i_reg + NUM_W'(1);
                end
            end
            ST_MARK_RD: begin
                state_next = ST_MARK_CHK;
            end
            ST_MARK_CHK: begin
                // A marked number breaks at its marking prime; a listed
                // prime at itself; an unlisted prime never breaks early.
                list_we  = append;
                cnt_next = cnt_after;
                div_next = append ? DIV_W'(i_reg) : DIV_W'(mark_q_reg);
                j_next   = '0;
                if (cnt_after == '0) begin
                    if (i_reg == bound_reg) begin
                        state_next = ST_EMIT_RD;
                    end else begin
                        i_next     = i_reg + NUM_W'(1);
                        state_next = ST_MARK_RD;
                    end
                end else begin
                    state_next = ST_LIST_RD;
                end
            end
            ST_LIST_RD: begin
                state_next = ST_PROD;
            end
            ST_PROD: begin
                p_next     = list_q_reg;
                prod_next  = PROD_W'(i_reg) * PROD_W'(list_q_reg);
                state_next = ST_MARK_WR;
            end
            ST_MARK_WR: begin
                if (prod_reg > PROD_W'(bound_reg)) begin
                    j_next = '0;
                    if (i_reg == bound_reg) begin
                        state_next = ST_EMIT_RD;
                    end else begin
                        i_next     = i_reg + NUM_W'(1);
                        state_next = ST_MARK_RD;
                    end
                end else begin
                    mark_we    = 1'b1;
                    mark_waddr = prod_reg[NUM_W-1:0];
                    mark_wdata = p_reg;
                    if ((DIV_W'(p_reg) == div_reg) || j_last) begin
                        j_next = '0;
                        if (i_reg == bound_reg) begin
                            state_next = ST_EMIT_RD;
                        end else begin
                            i_next     = i_reg + NUM_W'(1);
                            state_next = ST_MARK_RD;
                        end
                    end else begin
                        j_next     = j_reg + LIDX_W'(1);
                        state_next = ST_LIST_RD;
                    end
                end
            end
            ST_EMIT_RD: begin
                state_next = ST_EMIT_LD;
            end
            ST_EMIT_LD: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_val_next   = list_q_reg;
                    out_idx_next   = IDX_W'(j_reg);
                    out_found_next = 1'b1;
                    out_last_next  = j_last;
                    if (j_last) begin
                        state_next = ST_IDLE;
                    end else begin
                        j_next     = j_reg + LIDX_W'(1);
                        state_next = ST_EMIT_RD;
                    end
                end
            end
            ST_NONE: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_val_next   = '0;
                    out_idx_next   = '0;
                    out_found_next = 1'b0;
                    out_last_next  = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output port mapping.
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_DATA_W - VAL_W - IDX_W){1'b0}}, out_idx_reg, out_val_reg};
    assign m_tuser  = out_found_reg;
    assign m_tlast  = out_last_reg;

    // The prime count never passes the list depth.
    assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_W'(MAX_PRIMES))
        else $error("prime count exceeds list depth");

    // A marking write never lands beyond the current bound.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (mark_we && (state_reg == ST_MARK_WR)) |-> (mark_waddr <= bound_reg))
        else $error("mark write beyond bound");

    // A no-prime word is always the last word of its request.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser) |-> m_tlast)
        else $error("no-prime word without last");

    // A found prime is at least two.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (m_tdata[VAL_W-1:0] >= VAL_W'(2)))
        else $error("emitted prime below two");

    // Loading a last word returns the sequencer to idle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_next && out_last_next && !out_valid_reg) |=> (state_reg == ST_IDLE))
        else $error("sequencer busy after last word");

endmodule
